// ----- hw/rtl/sis_pkg.sv -----
// shared types and constants for the shuffled index sequencer
// used by sis_div and shuffled_index_sequencer; no dependencies
package sis_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;

   localparam logic OP_INIT    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
      logic [DATA_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- hw/rtl/sis_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on sis_pkg
module sis_div (
   input  logic                clock,
   input  logic                reset,
   input  sis_pkg::div_req_type div_req,
   output sis_pkg::div_rsp_type div_rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [sis_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [sis_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [sis_pkg::DATA_W-1:0] quo_ff, quo_in;
   logic [sis_pkg::DATA_W-1:0] dvs_ff, dvs_in;

   logic [sis_pkg::DATA_W:0]   shifted;
   logic [sis_pkg::DATA_W+1:0] diff;
   logic                       ge;

   assign shifted = {rem_ff, quo_ff[sis_pkg::DATA_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge      = ~diff[sis_pkg::DATA_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = {sis_pkg::CNT_W{1'b1}};
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[sis_pkg::DATA_W-1:0] : shifted[sis_pkg::DATA_W-1:0];
         quo_in = {quo_ff[sis_pkg::DATA_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- hw/rtl/shuffled_index_sequencer.sv -----
// shuffled index sequencer: sequencer around one shared 32-bit divider
// advance: one division (count mod quotient)
// initialize: four divisions in turn, three on the overflow fallback; length below 2: no division
// one item at a time; req_ready is high only while idle, the result waits in an output register
// synchronous active-high reset: position 0, step 1, bound 1, count 0; depends on sis_pkg, sis_div
module shuffled_index_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_opcode,
   input  logic [sis_pkg::DATA_W-1:0] req_length,
   input  logic [sis_pkg::DATA_W-1:0] req_rand_start,
   input  logic [sis_pkg::DATA_W-1:0] req_rand_step,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sis_pkg::DATA_W-1:0] rsp_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_D1   = 3'd1;
   localparam logic [2:0] ST_D2   = 3'd2;
   localparam logic [2:0] ST_D3   = 3'd3;
   localparam logic [2:0] ST_D4   = 3'd4;
   localparam logic [2:0] ST_ADV  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam int W = sis_pkg::DATA_W;

   logic [2:0]   state_ff, state_in;
   logic [W-1:0] position_ff, position_in;
   logic [W-1:0] step_ff, step_in;
   logic [W-1:0] bound_ff, bound_in;
   logic [W-1:0] count_ff, count_in;
   logic [W-1:0] quot_ff, quot_in;
   logic [W-1:0] len_ff, len_in;
   logic [W-1:0] rstep_ff, rstep_in;
   logic [W-1:0] result_ff, result_in;
   logic         start_ff, start_in;
   logic [W-1:0] dvd_ff, dvd_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_value_ff, rsp_value_in;

   sis_pkg::div_req_type div_req;
   sis_pkg::div_rsp_type div_rsp;

   logic [W-1:0] base;
   logic [W-1:0] inc;
   logic [W-1:0] gap;

   assign div_req.start    = start_ff;
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = dvs_ff;

   sis_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign base = len_ff - div_rsp.remainder;
   assign inc  = (quot_ff != '0 && div_rsp.remainder == '0) ? step_ff + 1'b1 : step_ff;
   assign gap  = bound_ff - position_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      step_in      = step_ff;
      bound_in     = bound_ff;
      count_in     = count_ff;
      quot_in      = quot_ff;
      len_in       = len_ff;
      rstep_in     = rstep_ff;
      result_in    = result_ff;
      start_in     = 1'b0;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == sis_pkg::OP_ADVANCE) begin
                  result_in = position_ff;
                  count_in  = count_ff + 1'b1;
                  start_in  = 1'b1;
                  dvd_in    = count_ff + 1'b1;
                  dvs_in    = quot_ff;
                  state_in  = ST_ADV;
               end else begin
                  count_in = '0;
                  len_in   = req_length;
                  rstep_in = req_rand_step;
                  if (req_length < W'(2)) begin
                     position_in = '0;
                     step_in     = W'(1);
                     bound_in    = req_length + 1'b1;
                     quot_in     = req_length + 1'b1;
                     result_in   = req_length + 1'b1;
                     state_in    = ST_DONE;
                  end else begin
                     start_in = 1'b1;
                     dvd_in   = req_rand_start;
                     dvs_in   = req_length;
                     state_in = ST_D1;
                  end
               end
            end
         end
         ST_D1: begin
            if (div_rsp.done) begin
               position_in = div_rsp.remainder;
               start_in    = 1'b1;
               dvd_in      = rstep_ff;
               dvs_in      = len_ff - 1'b1;
               state_in    = ST_D2;
            end
         end
         ST_D2: begin
            if (div_rsp.done) begin
               step_in  = div_rsp.remainder + 1'b1;
               start_in = 1'b1;
               dvd_in   = len_ff;
               dvs_in   = div_rsp.remainder + 1'b1;
               state_in = ST_D3;
            end
         end
         ST_D3: begin
            if (div_rsp.done) begin
               if (base > ~step_ff) begin
                  bound_in  = sis_pkg::ALL_ONES;
                  step_in   = W'(1);
                  quot_in   = sis_pkg::ALL_ONES;
                  result_in = sis_pkg::ALL_ONES;
                  state_in  = ST_DONE;
               end else begin
                  bound_in  = base + step_ff;
                  result_in = base + step_ff;
                  start_in  = 1'b1;
                  dvd_in    = base + step_ff;
                  dvs_in    = step_ff;
                  state_in  = ST_D4;
               end
            end
         end
         ST_D4: begin
            if (div_rsp.done) begin
               quot_in  = div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_ADV: begin
            if (div_rsp.done) begin
               if (inc >= gap) begin
                  position_in = position_ff + inc - bound_ff;
               end else begin
                  position_in = position_ff + inc;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         step_ff      <= W'(1);
         bound_ff     <= W'(1);
         count_ff     <= '0;
         quot_ff      <= W'(1);
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         step_ff      <= step_in;
         bound_ff     <= bound_in;
         count_ff     <= count_in;
         quot_ff      <= quot_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff       <= len_in;
      rstep_ff     <= rstep_in;
      result_ff    <= result_in;
      dvd_ff       <= dvd_in;
      dvs_ff       <= dvs_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// ----- test/testbench.sv -----
// testbench for shuffled_index_sequencer: directed and random init/advance items,
// results checked against an in-bench prediction of bound and visiting order
// depends on sis_pkg and the shuffled_index_sequencer rtl
`timescale 1ns / 100ps

module testbench;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_opcode = sis_pkg::OP_INIT;
   logic [sis_pkg::DATA_W-1:0] req_length = '0;
   logic [sis_pkg::DATA_W-1:0] req_rand_start = '0;
   logic [sis_pkg::DATA_W-1:0] req_rand_step = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [sis_pkg::DATA_W-1:0] rsp_value;

   logic [sis_pkg::DATA_W-1:0] idx_position = '0;
   logic [sis_pkg::DATA_W-1:0] idx_step     = 1;
   logic [sis_pkg::DATA_W-1:0] idx_bound    = 1;
   logic [sis_pkg::DATA_W-1:0] idx_count    = '0;

   logic [sis_pkg::DATA_W-1:0] pending_values[$];
   int                         mismatch_count = 0;
   int                         send_idle_pct  = 0;
   int                         recv_stall_pct = 0;

   shuffled_index_sequencer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_length     (req_length),
      .req_rand_start (req_rand_start),
      .req_rand_step  (req_rand_step),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [sis_pkg::DATA_W-1:0] predict_init_bound(
         input logic [sis_pkg::DATA_W-1:0] len,
         input logic [sis_pkg::DATA_W-1:0] r1,
         input logic [sis_pkg::DATA_W-1:0] r2);
      logic [sis_pkg::DATA_W-1:0] base;
      idx_count = '0;
      if (len < 2) begin
         idx_position = '0;
         idx_step     = 1;
         idx_bound    = len + 1;
      end else begin
         idx_position = r1 % len;
         idx_step     = (r2 % (len - 1)) + 1;
         base         = len - (len % idx_step);
         if (base > sis_pkg::ALL_ONES - idx_step) begin
            idx_bound = sis_pkg::ALL_ONES;
            idx_step  = 1;
         end else begin
            idx_bound = base + idx_step;
         end
      end
      return idx_bound;
   endfunction

   function automatic logic [sis_pkg::DATA_W-1:0] predict_next_index();
      logic [sis_pkg::DATA_W-1:0] cur;
      logic [sis_pkg::DATA_W-1:0] inc;
      logic [sis_pkg::DATA_W-1:0] quot;
      cur  = idx_position;
      inc  = idx_step;
      quot = (idx_step != 0) ? idx_bound / idx_step : '0;
      idx_count = idx_count + 1;
      if (quot != 0 && (idx_count % quot) == 0)
         inc = inc + 1;
      if (inc >= sis_pkg::DATA_W'(idx_bound - idx_position))
         idx_position = idx_position + inc - idx_bound;
      else
         idx_position = idx_position + inc;
      return cur;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t ERROR: %s", $realtime, msg);
   endtask

   // the valid line is only lowered in a step that is followed by a clock wait
   task automatic send_item(input logic op, input logic [sis_pkg::DATA_W-1:0] len,
                            input logic [sis_pkg::DATA_W-1:0] r1,
                            input logic [sis_pkg::DATA_W-1:0] r2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_length     <= len;
      req_rand_start <= r1;
      req_rand_step  <= r2;
      do @(posedge clock); while (!req_ready);
      if (op == sis_pkg::OP_INIT)
         pending_values.push_back(predict_init_bound(len, r1, r2));
      else
         pending_values.push_back(predict_next_index());
   endtask

   task automatic send_advances(input int n);
      repeat (n) send_item(sis_pkg::OP_ADVANCE, $urandom, $urandom, $urandom);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
   endtask

   always @(posedge clock) begin
      logic [sis_pkg::DATA_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected item, value %h", rsp_value));
         end else begin
            want = pending_values.pop_front();
            if (rsp_value !== want)
               report_mismatch($sformatf("value %h, expected %h", rsp_value, want));
         end
      end
   end

   function automatic logic [sis_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return sis_pkg::ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [sis_pkg::DATA_W-1:0] pick_length();
      case ($urandom_range(4))
         0: return $urandom_range(20);
         1: return $urandom_range(1000);
         2: return sis_pkg::ALL_ONES - $urandom_range(16);
         default: return $urandom;
      endcase
   endfunction

   // walk from the reset state: bound 1, so every advance adds two and wraps back by one
   task automatic test_reset_state();
      send_advances(3);
   endtask

   task automatic test_short_ranges();
      send_item(sis_pkg::OP_INIT, 0, sis_pkg::ALL_ONES, sis_pkg::ALL_ONES);
      send_advances(2);
      send_item(sis_pkg::OP_INIT, 1, sis_pkg::ALL_ONES, 0);
      send_advances(3);
      send_item(sis_pkg::OP_INIT, 2, sis_pkg::ALL_ONES, sis_pkg::ALL_ONES);
      send_advances(2);
   endtask

   // overflow fallback and a bound just below the top of the range
   task automatic test_wide_ranges();
      send_item(sis_pkg::OP_INIT, sis_pkg::ALL_ONES, 0, 0);
      send_advances(1);
      send_item(sis_pkg::OP_INIT, sis_pkg::ALL_ONES, sis_pkg::ALL_ONES, 32'hFFFF_FFFD);
      send_advances(1);
      send_item(sis_pkg::OP_INIT, 32'h8000_0000, sis_pkg::ALL_ONES, 32'h7FFF_FFFE);
      send_advances(3);
      send_item(sis_pkg::OP_INIT, 10, 32'h0000_1234, 32'h0000_0007);
      send_advances(2);
   endtask

   task automatic run_traffic(input int send_pct, input int recv_pct, input int n_items);
      int sent;
      int burst;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(15) == 0) begin
            send_item(sis_pkg::OP_ADVANCE, $urandom, $urandom, $urandom);
            sent++;
         end else begin
            send_item(sis_pkg::OP_INIT, pick_length(), pick_word(), pick_word());
            burst = $urandom_range(12);
            send_advances(burst);
            sent += burst + 1;
         end
         if ($urandom_range(9) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      run_traffic(22, 65, 280);
      run_traffic(65, 22, 280);
      run_traffic(0, 0, 290);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_short_ranges();
      test_wide_ranges();
      wait_drained();
      test_random_traffic();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
